/* rtl/gpvt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the gradient palette vertex tint block.
// No dependencies; every rtl file refers to it by scoped names.
package gpvt_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int COLOR_W  = CHAN_W * NUM_CH;
    localparam int IDX_W    = 8;
    localparam int SEG_BITS = 6;                     // 64 steps per segment
    localparam int DIFF_W   = CHAN_W + 1;
    localparam int ACC_W    = 16;
    localparam int POS_W    = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CHAN_W-1:0] BLEND_MULTIPLY = 8'd1;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_SHADE   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_A    = 2'd0,
        CFG_COLOR_B    = 2'd1,
        CFG_COLOR_C    = 2'd2,
        CFG_BLEND_MODE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEG_A_TO_B = 2'd0,
        SEG_B_TO_C = 2'd1,
        SEG_C_TO_B = 2'd2,
        SEG_B_TO_A = 2'd3
    } seg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [COLOR_W-1:0] color_c;
        chan_t              blend_mode;
    } cfg_regs_t;

    // index 0 is red, 1 green, 2 blue
    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        chan_t [NUM_CH-1:0]     src;
    } idx_beat_t;

    typedef struct packed {
        chan_t [NUM_CH-1:0]                 first;
        logic [NUM_CH-1:0][DIFF_W-1:0]      diff;
        logic [SEG_BITS-1:0]                step;
        chan_t [NUM_CH-1:0]                 src;
    } ramp_beat_t;

    typedef struct packed {
        chan_t [NUM_CH-1:0] grad;
        chan_t [NUM_CH-1:0] src;
    } grad_beat_t;

    // channel ch of a packed color: red 23:16, green 15:8, blue 7:0
    function automatic chan_t chan_of(logic [COLOR_W-1:0] color, logic [1:0] ch);
        chan_t res;
        case (ch)
            2'd0:    res = color[23:16];
            2'd1:    res = color[15:8];
            default: res = color[7:0];
        endcase
        return res;
    endfunction

endpackage

/* rtl/gpvt_index.sv */
`timescale 1ns / 1ps
// Input stage: holds the phase, applies advance beats and forms the gradient index.
// Depends on gpvt_pkg.
module gpvt_index (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  gpvt_pkg::cmd_t              in_cmd,
    input  logic [gpvt_pkg::CHAN_W-1:0] in_step,
    input  logic [gpvt_pkg::POS_W-1:0]  in_pos_x,
    input  logic [gpvt_pkg::POS_W-1:0]  in_pos_y,
    input  logic [gpvt_pkg::POS_W-1:0]  in_pos_z,
    input  gpvt_pkg::chan_t [gpvt_pkg::NUM_CH-1:0] in_src,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gpvt_pkg::idx_beat_t         out_beat
);

    logic [gpvt_pkg::IDX_W-1:0] phase_reg, phase_next;
    logic                       valid_reg, valid_next;
    gpvt_pkg::idx_beat_t        beat_reg, beat_next;
    logic                       accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (in_ready) begin
            valid_next = in_valid && (in_cmd == gpvt_pkg::CMD_SHADE);
        end
        if (accept) begin
            if (in_cmd == gpvt_pkg::CMD_ADVANCE) begin
                phase_next = phase_reg + in_step;
            end
            beat_next.idx = in_pos_x[gpvt_pkg::IDX_W-1:0] + in_pos_y[gpvt_pkg::IDX_W-1:0]
                          + in_pos_z[gpvt_pkg::IDX_W-1:0] + phase_reg;
            beat_next.src = in_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* rtl/gpvt_ramp.sv */
`timescale 1ns / 1ps
// Gradient stages: segment endpoint select, then the linear interpolation.
// Depends on gpvt_pkg.
module gpvt_ramp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpvt_pkg::cfg_regs_t   cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpvt_pkg::idx_beat_t   in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpvt_pkg::grad_beat_t  out_beat
);

    logic                 sel_valid_reg, sel_valid_next;
    gpvt_pkg::ramp_beat_t sel_beat_reg, sel_beat_next;
    logic                 sel_ready;
    logic                 mix_valid_reg, mix_valid_next;
    gpvt_pkg::grad_beat_t mix_beat_reg, mix_beat_next;

    assign sel_ready = !mix_valid_reg || out_ready;
    assign in_ready  = !sel_valid_reg || sel_ready;

    // endpoint select
    always_comb begin
        logic [gpvt_pkg::COLOR_W-1:0] from_c;
        logic [gpvt_pkg::COLOR_W-1:0] to_c;
        gpvt_pkg::chan_t              f;
        gpvt_pkg::chan_t              l;
        f = '0;
        l = '0;
        case (gpvt_pkg::seg_t'(in_beat.idx[gpvt_pkg::IDX_W-1:gpvt_pkg::SEG_BITS]))
            gpvt_pkg::SEG_A_TO_B: begin
                from_c = cfg.color_a;
                to_c   = cfg.color_b;
            end
            gpvt_pkg::SEG_B_TO_C: begin
                from_c = cfg.color_b;
                to_c   = cfg.color_c;
            end
            gpvt_pkg::SEG_C_TO_B: begin
                from_c = cfg.color_c;
                to_c   = cfg.color_b;
            end
            default: begin
                from_c = cfg.color_b;
                to_c   = cfg.color_a;
            end
        endcase
        sel_valid_next = sel_valid_reg;
        sel_beat_next  = sel_beat_reg;
        if (in_ready) begin
            sel_valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            for (int ch = 0; ch < gpvt_pkg::NUM_CH; ch++) begin
                f = gpvt_pkg::chan_of(from_c, 2'(ch));
                l = gpvt_pkg::chan_of(to_c, 2'(ch));
                sel_beat_next.first[ch] = f;
                sel_beat_next.diff[ch]  = {1'b0, l} - {1'b0, f};
            end
            sel_beat_next.step = in_beat.idx[gpvt_pkg::SEG_BITS-1:0];
            sel_beat_next.src  = in_beat.src;
        end
    end

    // interpolate: (first*64 + step*diff) / 64, never negative
    always_comb begin
        logic signed [gpvt_pkg::ACC_W-1:0] acc;
        mix_valid_next = mix_valid_reg;
        mix_beat_next  = mix_beat_reg;
        acc            = '0;
        if (sel_ready) begin
            mix_valid_next = sel_valid_reg;
        end
        if (sel_valid_reg && sel_ready) begin
            for (int ch = 0; ch < gpvt_pkg::NUM_CH; ch++) begin
                acc = $signed({2'b00, sel_beat_reg.first[ch], {gpvt_pkg::SEG_BITS{1'b0}}})
                    + $signed({1'b0, sel_beat_reg.step})
                    * $signed(sel_beat_reg.diff[ch]);
                mix_beat_next.grad[ch] =
                    acc[gpvt_pkg::SEG_BITS +: gpvt_pkg::CHAN_W];
            end
            mix_beat_next.src = sel_beat_reg.src;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
            mix_valid_reg <= 1'b0;
        end else begin
            sel_valid_reg <= sel_valid_next;
            mix_valid_reg <= mix_valid_next;
        end
        sel_beat_reg <= sel_beat_next;
        mix_beat_reg <= mix_beat_next;
    end

    assign out_valid = mix_valid_reg;
    assign out_beat  = mix_beat_reg;

endmodule

/* rtl/gpvt_blend.sv */
`timescale 1ns / 1ps
// Output stage: multiply or maximum blend of source and gradient, output register.
// Depends on gpvt_pkg.
module gpvt_blend (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpvt_pkg::chan_t       blend_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpvt_pkg::grad_beat_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpvt_pkg::chan_t [gpvt_pkg::NUM_CH-1:0] out_color
);

    logic                                   valid_reg, valid_next;
    gpvt_pkg::chan_t [gpvt_pkg::NUM_CH-1:0] color_reg, color_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [2*gpvt_pkg::CHAN_W-1:0] prod;
        valid_next = valid_reg;
        color_next = color_reg;
        prod       = '0;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            for (int ch = 0; ch < gpvt_pkg::NUM_CH; ch++) begin
                prod = in_beat.src[ch] * in_beat.grad[ch];
                if (blend_mode == gpvt_pkg::BLEND_MULTIPLY) begin
                    color_next[ch] = prod[gpvt_pkg::CHAN_W +: gpvt_pkg::CHAN_W];
                end else if (in_beat.grad[ch] < in_beat.src[ch]) begin
                    color_next[ch] = in_beat.src[ch];
                end else begin
                    color_next[ch] = in_beat.grad[ch];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        color_reg <= color_next;
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

/* rtl/gradient_palette_vertex_tint_top.sv */
`timescale 1ns / 1ps
// Top level of the gradient palette vertex tint block: config registers and pipeline.
// Depends on gpvt_pkg, gpvt_index, gpvt_ramp and gpvt_blend.
//
// Usage:
//   s_ channel carries commands. s_tuser = 0 advances the gradient phase by the
//   phase_step byte and gives no result; s_tuser = 1 shades one vertex and gives
//   exactly one m_ beat with the tinted color.
//   The gradient index is the sum of the low bytes of x, y, z and the phase.
//   cfg_wr_en/cfg_index/cfg_wdata write color_a (0), color_b (1), color_c (2) and
//   blend_mode (3); write only while the pipeline is empty.
//   A shade beat enters the index register on the accepting edge, then passes
//   the endpoint select, interpolation multiply and blend registers before it
//   shows on m_tvalid.
//   Throughput: one beat per cycle while m_tready is high, set by the four register stages.
//   Reset clears phase, config registers and all stage valid bits.
//   When m_tready is low the output beat holds; empty stages behind it keep
//   filling, so s_tready drops only once all four stages hold a beat.
module gradient_palette_vertex_tint_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // phase_step, pos_x, pos_y, pos_z, in_red, in_green, in_blue
    input  logic [gpvt_pkg::IN_DATA_W-1:0]    s_tdata,
    // command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_red, out_green, out_blue
    output logic [gpvt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [gpvt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpvt_pkg::COLOR_W-1:0]      cfg_wdata
);

    gpvt_pkg::cfg_regs_t  cfg_reg, cfg_next;
    logic                 idx_valid, idx_ready;
    gpvt_pkg::idx_beat_t  idx_beat;
    logic                 ramp_valid, ramp_ready;
    gpvt_pkg::grad_beat_t ramp_beat;
    gpvt_pkg::chan_t [gpvt_pkg::NUM_CH-1:0] src_color;
    gpvt_pkg::chan_t [gpvt_pkg::NUM_CH-1:0] out_color;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (gpvt_pkg::cfg_idx_t'(cfg_index))
                gpvt_pkg::CFG_COLOR_A:    cfg_next.color_a = cfg_wdata;
                gpvt_pkg::CFG_COLOR_B:    cfg_next.color_b = cfg_wdata;
                gpvt_pkg::CFG_COLOR_C:    cfg_next.color_c = cfg_wdata;
                gpvt_pkg::CFG_BLEND_MODE:
                    cfg_next.blend_mode = cfg_wdata[gpvt_pkg::CHAN_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign src_color[0] = s_tdata[63:56];
    assign src_color[1] = s_tdata[71:64];
    assign src_color[2] = s_tdata[79:72];

    gpvt_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (gpvt_pkg::cmd_t'(s_tuser)),
        .in_step   (s_tdata[7:0]),
        .in_pos_x  (s_tdata[23:8]),
        .in_pos_y  (s_tdata[39:24]),
        .in_pos_z  (s_tdata[55:40]),
        .in_src    (src_color),
        .out_valid (idx_valid),
        .out_ready (idx_ready),
        .out_beat  (idx_beat)
    );

    gpvt_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .in_beat   (idx_beat),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_beat  (ramp_beat)
    );

    gpvt_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blend_mode (cfg_reg.blend_mode),
        .in_valid   (ramp_valid),
        .in_ready   (ramp_ready),
        .in_beat    (ramp_beat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (out_color)
    );

    assign m_tdata = {out_color[2], out_color[1], out_color[0]};

`ifndef SYNTHESIS
    // a free output slot must propagate back to the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // an advance beat must never enter the shade pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == gpvt_pkg::CMD_ADVANCE)) |=> !idx_valid)
        else $error("advance beat produced a shade beat");

    // a new output beat needs a beat from the gradient stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ramp_valid))
        else $error("output beat without a gradient beat");
`endif

endmodule

/* sim/tint_checker.sv */
`timescale 1ns / 1ps
// Checker for the gradient palette vertex tint block: predicts each tinted vertex from
// the s_ beats and register writes it observes, then compares against the m_ beats.
// Depends on gpvt_pkg.
module tint_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [gpvt_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [gpvt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [gpvt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpvt_pkg::COLOR_W-1:0]      cfg_wdata,
    output int                                mismatches,
    output int                                in_flight
);
    import gpvt_pkg::*;

    localparam int RAMP_STEPS = 1 << SEG_BITS;

    // element 0 is red, 1 green, 2 blue
    typedef chan_t [NUM_CH-1:0] tint_t;

    cfg_regs_t        palette;
    logic [IDX_W-1:0] phase;
    tint_t            pending_tints[$];
    int               errs;
    string            chan_name[NUM_CH] = '{"out_red", "out_green", "out_blue"};

    function automatic chan_t gradient_level(logic [IDX_W-1:0] idx, int ch);
        logic [COLOR_W-1:0] from;
        logic [COLOR_W-1:0] to;
        int                 f;
        int                 l;
        int                 acc;
        case (seg_t'(idx[IDX_W-1:SEG_BITS]))
            SEG_A_TO_B: begin
                from = palette.color_a;
                to   = palette.color_b;
            end
            SEG_B_TO_C: begin
                from = palette.color_b;
                to   = palette.color_c;
            end
            SEG_C_TO_B: begin
                from = palette.color_c;
                to   = palette.color_b;
            end
            default: begin
                from = palette.color_b;
                to   = palette.color_a;
            end
        endcase
        f   = int'(from[CHAN_W * (NUM_CH - 1 - ch) +: CHAN_W]);
        l   = int'(to[CHAN_W * (NUM_CH - 1 - ch) +: CHAN_W]);
        acc = f * RAMP_STEPS + int'(idx[SEG_BITS-1:0]) * (l - f);
        return chan_t'(acc / RAMP_STEPS);
    endfunction

    function automatic tint_t shade_vertex(logic [IDX_W-1:0] idx, tint_t src);
        tint_t       res;
        chan_t       g;
        logic [15:0] prod;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            g = gradient_level(idx, ch);
            if (palette.blend_mode == BLEND_MULTIPLY) begin
                prod    = 16'(src[ch]) * 16'(g);
                res[ch] = prod[15:8];
            end else begin
                res[ch] = (g < src[ch]) ? src[ch] : g;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        logic [IDX_W-1:0] idx;
        tint_t            want;
        tint_t            got;
        if (!aresetn) begin
            palette = '0;
            phase   = '0;
            errs    = 0;
            pending_tints.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COLOR_A:    palette.color_a    = cfg_wdata;
                    CFG_COLOR_B:    palette.color_b    = cfg_wdata;
                    CFG_COLOR_C:    palette.color_c    = cfg_wdata;
                    CFG_BLEND_MODE: palette.blend_mode = cfg_wdata[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_tints.size() == 0) begin
                    $error("result beat %h with no vertex pending", m_tdata);
                    errs++;
                end else begin
                    want = pending_tints.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (got[ch] !== want[ch]) begin
                            $error("%s: expected %0d, got %0d", chan_name[ch], want[ch], got[ch]);
                            errs++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (cmd_t'(s_tuser) == CMD_ADVANCE) begin
                    phase = phase + s_tdata[7:0];
                end else begin
                    idx = s_tdata[15:8] + s_tdata[31:24] + s_tdata[47:40] + phase;
                    pending_tints.push_back(shade_vertex(idx, s_tdata[56 +: COLOR_W]));
                end
            end
        end
        mismatches <= errs;
        in_flight  <= pending_tints.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the gradient palette vertex tint testbench: clock, reset, stimulus and verdict.
// Depends on gpvt_pkg, gradient_palette_vertex_tint_top and tint_checker.
module testbench;
    import gpvt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COLOR_W-1:0]    cfg_wdata = '0;

    int mismatches;
    int in_flight;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int ramp_marks[8]  = '{0, 63, 64, 127, 128, 191, 192, 255};

    gradient_palette_vertex_tint_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tint_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(cmd_t cmd, logic [7:0] step, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                            chan_t red, chan_t green, chan_t blue);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {blue, green, red, z, y, x, step};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every pending vertex has come back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_palette(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                                logic [COLOR_W-1:0] c, chan_t mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLOR_A;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_index <= CFG_COLOR_B;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_index <= CFG_COLOR_C;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_index <= CFG_BLEND_MODE;
        cfg_wdata <= {16'($urandom), mode};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic chan_t pick_chan();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic chan_t pick_mode();
        case ($urandom_range(0, 3))
            0:       return BLEND_MULTIPLY;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset palette is all black in maximum mode
        send_cmd(CMD_SHADE, 8'h5A, 16'h0010, 16'h0000, 16'h0000, 8'h80, 8'h00, 8'hFF);
        settle();
        load_palette(24'hFF1080, 24'h00FFFF, 24'h7F0000, 8'h00);
        foreach (ramp_marks[i]) begin
            send_cmd(CMD_SHADE, 8'h00, 16'(ramp_marks[i]), 16'h0000, 16'h0000,
                     8'h00, 8'h00, 8'h00);
        end
        send_cmd(CMD_SHADE, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_ADVANCE, 8'hFF, 16'h1234, 16'hFFFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_ADVANCE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_ADVANCE, 8'h01, 16'h7FFF, 16'h0001, 16'hFFFF, 8'h12, 8'h34, 8'h56);
        send_cmd(CMD_ADVANCE, 8'hC8, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_SHADE, 8'h00, 16'h0064, 16'h0000, 16'h0000, 8'h40, 8'hC0, 8'h20);
        send_cmd(CMD_SHADE, 8'hAA, 16'hFF80, 16'hFFC0, 16'h8001, 8'h00, 8'hFF, 8'h7F);
        settle();
        load_palette(24'hFF1080, 24'h00FFFF, 24'h7F0000, BLEND_MULTIPLY);
        send_cmd(CMD_SHADE, 8'h00, 16'h0040, 16'h0000, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_SHADE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_SHADE, 8'h00, 16'h00C0, 16'h0010, 16'h0000, 8'h80, 8'hFF, 8'h01);
        settle();
        load_palette(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 8'h02);
        send_cmd(CMD_SHADE, 8'h00, 16'h0020, 16'h0000, 16'h0000, 8'h80, 8'h00, 8'hFF);
        send_cmd(CMD_SHADE, 8'h00, 16'h00A0, 16'h0000, 16'h0000, 8'h80, 8'h00, 8'hFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            load_palette(pick_color(), pick_color(), pick_color(), pick_mode());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 1) begin
                    settle();
                end
                send_cmd(($urandom_range(0, 3) == 0) ? CMD_ADVANCE : CMD_SHADE,
                         8'($urandom_range(0, 255)), pick_pos(), pick_pos(), pick_pos(),
                         pick_chan(), pick_chan(), pick_chan());
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
